/* rtl/core/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types, constants and helpers of the delimited frame search block.
// ----------------------------------------------------------------------------
`default_nettype none

package dfs_pkg;

    localparam int DEPTH    = 256;
    localparam int AW       = 8;
    localparam int CW       = 9;
    localparam int PW       = 10;
    localparam int MAXP     = 8;
    localparam int PATW     = 64;
    localparam int CFG_AW   = 3;
    localparam int IN_DW    = 16;
    localparam int OUT_DW   = 40;

    localparam logic [CW-1:0] FULL_FILL = CW'(DEPTH);
    localparam logic [3:0]    MAXP_LEN  = 4'(MAXP);

    typedef enum logic [CFG_AW-1:0] {
        REG_HEAD_PATTERN = 3'd0,
        REG_HEAD_LEN     = 3'd1,
        REG_TAIL_PATTERN = 3'd2,
        REG_TAIL_LEN     = 3'd3,
        REG_MIN_LEN      = 3'd4,
        REG_MAX_LEN      = 3'd5,
        REG_FRAME_POLICY = 3'd6
    } reg_idx_t;

    localparam logic [1:0] POL_SOFT   = 2'd0;
    localparam logic [1:0] POL_MEDIUM = 2'd1;
    localparam logic [1:0] POL_HARD   = 2'd2;

    localparam logic CMD_PUSH   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam int FLG_DROP_BEFORE = 0;
    localparam int FLG_DROP_ONE    = 1;
    localparam int FLG_DROP_FRAME  = 2;
    localparam int FLG_DROP_FULL   = 3;
    localparam int FLG_SKIP_HEAD   = 4;

    typedef struct packed {
        logic [PATW-1:0] head_pattern;
        logic [3:0]      head_len;
        logic [PATW-1:0] tail_pattern;
        logic [3:0]      tail_len;
        logic [CW-1:0]   min_len;
        logic [CW-1:0]   max_len;
        logic [1:0]      policy;
    } cfg_t;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CHECK = 10'b0000000010,
        ST_A_RD  = 10'b0000000100,
        ST_A_EV  = 10'b0000001000,
        ST_S_RD  = 10'b0000010000,
        ST_SCAN  = 10'b0000100000,
        ST_DROP  = 10'b0001000000,
        ST_H0_RD = 10'b0010000000,
        ST_H0_EV = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    function automatic logic [7:0] pat_byte(input logic [PATW-1:0] pat, input logic [2:0] idx);
        return pat[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/dfs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// dfs_cfg_regs
// Configuration register file; presents pattern lengths saturated and the
// policy folded to its legal codes.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [dfs_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [dfs_pkg::PATW-1:0]     cfg_wdata,
    output dfs_pkg::cfg_t                     cfg
);

    logic [dfs_pkg::PATW-1:0] head_pattern_reg;
    logic [3:0]               head_len_reg;
    logic [dfs_pkg::PATW-1:0] tail_pattern_reg;
    logic [3:0]               tail_len_reg;
    logic [dfs_pkg::CW-1:0]   min_len_reg;
    logic [dfs_pkg::CW-1:0]   max_len_reg;
    logic [1:0]               policy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_pattern_reg <= '0;
            head_len_reg     <= 4'd1;
            tail_pattern_reg <= '0;
            tail_len_reg     <= '0;
            min_len_reg      <= '0;
            max_len_reg      <= '0;
            policy_reg       <= dfs_pkg::POL_SOFT;
        end else if (cfg_we) begin
            unique case (dfs_pkg::reg_idx_t'(cfg_addr))
                dfs_pkg::REG_HEAD_PATTERN: head_pattern_reg <= cfg_wdata;
                dfs_pkg::REG_HEAD_LEN:     head_len_reg     <= cfg_wdata[3:0];
                dfs_pkg::REG_TAIL_PATTERN: tail_pattern_reg <= cfg_wdata;
                dfs_pkg::REG_TAIL_LEN:     tail_len_reg     <= cfg_wdata[3:0];
                dfs_pkg::REG_MIN_LEN:      min_len_reg      <= cfg_wdata[dfs_pkg::CW-1:0];
                dfs_pkg::REG_MAX_LEN:      max_len_reg      <= cfg_wdata[dfs_pkg::CW-1:0];
                dfs_pkg::REG_FRAME_POLICY: policy_reg       <= cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.head_pattern = head_pattern_reg;
        cfg.head_len     = (head_len_reg > dfs_pkg::MAXP_LEN) ? dfs_pkg::MAXP_LEN : head_len_reg;
        cfg.tail_pattern = tail_pattern_reg;
        cfg.tail_len     = (tail_len_reg > dfs_pkg::MAXP_LEN) ? dfs_pkg::MAXP_LEN : tail_len_reg;
        cfg.min_len      = min_len_reg;
        cfg.max_len      = max_len_reg;
        cfg.policy       = (policy_reg > dfs_pkg::POL_HARD) ? dfs_pkg::POL_SOFT : policy_reg;
    end

endmodule

`default_nettype wire

/* rtl/core/delimited_frame_search_top.sv */
// ----------------------------------------------------------------------------
// delimited_frame_search_top
// Circular byte store with a head/tail delimited frame finder.
//
// Channel   Dir  Content (lowest bits first)
// s_        in   tuser: command; tdata: data_byte[7:0], shift_flags[12:8]
// m_        out  tuser: found; tdata: frame_start, frame_len, frame_mem_index,
//                fill_after, overflow
// cfg_      in   write enable, register index, 64-bit write data
//
// A push passes through ST_OUT to the registered result; input is ready again as it appears.
// A search reads and evaluates each byte of the store in the match pass (one
// memory read port), then reads and decides each scan step, including steps
// repeated after an aborted candidate, then examines bytes one at a time in the
// skip; a store too short for a frame skips the match pass and the scan.
// Reset is synchronous and clears control state only; the store is undefined.
// Input is taken only when idle; a pending result may wait on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_frame_search_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [dfs_pkg::IN_DW-1:0]     s_tdata,   // data_byte, shift_flags
    input  wire logic                          s_tuser,   // command
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [dfs_pkg::OUT_DW-1:0]    m_tdata,   // frame_start, frame_len,
                                                          // frame_mem_index, fill_after,
                                                          // overflow
    output      logic                          m_tuser,   // found
    input  wire logic                          cfg_we,
    input  wire logic [dfs_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [dfs_pkg::PATW-1:0]      cfg_wdata
);

    localparam int AW = dfs_pkg::AW;
    localparam int CW = dfs_pkg::CW;
    localparam int PW = dfs_pkg::PW;

    dfs_pkg::cfg_t   cfg;
    dfs_pkg::state_t state_reg, state_next;

    logic [7:0]    mem [dfs_pkg::DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] raddr;
    logic          mem_we;

    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [4:0]    flags_reg, flags_next;
    logic [PW-1:0] t_reg, t_next;
    logic [CW-1:0] b_reg, b_next;
    logic [AW-1:0] sp_reg, sp_next;
    logic          inside_reg, inside_next;
    logic [7:0]    win_reg [8];
    logic [7:0]    w_new [8];
    logic [7:0]    hh_reg, hh_next;
    logic [7:0]    th_reg, th_next;

    logic          res_found_reg, res_found_next;
    logic [CW-1:0] res_start_reg, res_start_next;
    logic [CW-1:0] res_len_reg, res_len_next;
    logic [AW-1:0] res_mem_reg, res_mem_next;
    logic          res_ovf_reg, res_ovf_next;

    logic                       m_tvalid_reg, m_tvalid_next;
    logic [dfs_pkg::OUT_DW-1:0] m_tdata_reg;
    logic                       m_tuser_reg;
    logic                       out_load;

    logic [dfs_pkg::DEPTH-1:0] hend_reg, tend_reg, hcov_reg, tcov_reg, hb_reg, tb_reg;
    logic          se_hend_reg, se_tend_reg, se_hcov_reg, se_tcov_reg, se_hb_reg, se_tb_reg;

    logic          in_acc;
    logic [3:0]    hl, tl;
    logic          byte_ok, h_hit, t_hit, h_end, t_end, h_any, t_any, h_cov, t_cov;
    logic [PW-1:0] t_inc, hq, tq, need;
    logic          h_q_ok, t_q_ok;
    logic [7:0]    hmask, tmask;
    logic [CW-1:0] b_lim, cur, tidx;
    logic [AW-1:0] bi;
    logic          forb, last, first;
    logic [PW-1:0] k;
    logic [CW-1:0] ks;

    dfs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign hl       = cfg.head_len;
    assign tl       = cfg.tail_len;
    assign s_tready = (state_reg == dfs_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign mem_we   = in_acc && (s_tuser == dfs_pkg::CMD_PUSH) && (fill_reg != dfs_pkg::FULL_FILL);
    assign raddr    = (state_reg == dfs_pkg::ST_A_RD) ? oldest_reg + t_reg[AW-1:0] : oldest_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[oldest_reg + fill_reg[AW-1:0]] <= s_tdata[7:0];
        end
        rdata_reg <= mem[raddr];
    end

    // per-byte match pass
    always_comb begin
        w_new[0] = rdata_reg;
        for (int i = 1; i < 8; i++) begin
            w_new[i] = win_reg[i-1];
        end
        h_hit = 1'b1;
        t_hit = 1'b1;
        h_any = 1'b0;
        t_any = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < hl) begin
                if (w_new[i] != dfs_pkg::pat_byte(cfg.head_pattern, 3'(hl - 4'(i) - 4'd1)))
                    h_hit = 1'b0;
                if (rdata_reg == dfs_pkg::pat_byte(cfg.head_pattern, 3'(i)))
                    h_any = 1'b1;
            end
            if (4'(i) < tl) begin
                if (w_new[i] != dfs_pkg::pat_byte(cfg.tail_pattern, 3'(tl - 4'(i) - 4'd1)))
                    t_hit = 1'b0;
                if (rdata_reg == dfs_pkg::pat_byte(cfg.tail_pattern, 3'(i)))
                    t_any = 1'b1;
            end
        end
        t_inc   = t_reg + PW'(1);
        byte_ok = t_reg < {1'b0, fill_reg};
        h_end   = byte_ok && h_hit && (hl != 4'd0) && (t_inc >= PW'(hl));
        t_end   = byte_ok && t_hit && (tl != 4'd0) && (t_inc >= PW'(tl));
        hh_next = {hh_reg[6:0], h_end};
        th_next = {th_reg[6:0], t_end};
        hmask   = 8'((9'd1 << hl) - 9'd1);
        tmask   = 8'((9'd1 << tl) - 9'd1);
        h_cov   = |(hh_next & hmask);
        t_cov   = |(th_next & tmask);
        hq      = t_inc - PW'(hl);
        tq      = t_inc - PW'(tl);
        h_q_ok  = (t_inc >= PW'(hl)) && (hq < {1'b0, fill_reg});
        t_q_ok  = (tl != 4'd0) && (t_inc >= PW'(tl)) && (tq < {1'b0, fill_reg});
    end

    always_ff @(posedge aclk) begin
        if (state_reg == dfs_pkg::ST_A_EV) begin
            win_reg <= w_new;
            if (byte_ok) begin
                hend_reg[t_reg[AW-1:0]] <= h_end;
                tend_reg[t_reg[AW-1:0]] <= t_end;
                hb_reg[t_reg[AW-1:0]]   <= h_any;
                tb_reg[t_reg[AW-1:0]]   <= t_any;
            end
            if (h_q_ok) begin
                hcov_reg[hq[AW-1:0]] <= h_cov;
            end
            if (t_q_ok) begin
                tcov_reg[tq[AW-1:0]] <= t_cov;
            end
        end
        if (state_reg == dfs_pkg::ST_S_RD) begin
            se_hend_reg <= hend_reg[bi];
            se_tend_reg <= tend_reg[tidx[AW-1:0]];
            se_hcov_reg <= hcov_reg[bi];
            se_tcov_reg <= tcov_reg[bi];
            se_hb_reg   <= hb_reg[bi];
            se_tb_reg   <= tb_reg[bi];
        end
    end

    // scan step and drop amount
    always_comb begin
        b_lim = fill_reg - CW'(tl);
        bi    = b_reg[AW-1:0];
        cur   = inside_reg ? b_reg - {1'b0, sp_reg} : '0;
        tidx  = b_reg + CW'(tl);
        forb  = ((cfg.policy != dfs_pkg::POL_SOFT) &&
                 (se_hcov_reg || ((tl != 4'd0) && se_tcov_reg) ||
                  ((cfg.policy == dfs_pkg::POL_HARD) && (se_hb_reg || se_tb_reg)))) ||
                ((cfg.max_len != '0) && (cur > cfg.max_len));
        last  = (cur >= cfg.min_len) && ((tl == 4'd0) || se_tend_reg);
        first = se_hend_reg;
        need  = PW'(hl) + {1'b0, cfg.min_len} + PW'(tl);
        if (res_found_reg) begin
            if (|flags_reg[2:0]) begin
                k = {1'b0, res_start_reg} +
                    (flags_reg[dfs_pkg::FLG_DROP_FRAME] ? {1'b0, res_len_reg} :
                     flags_reg[dfs_pkg::FLG_DROP_ONE]   ? PW'(1) : PW'(0));
            end else begin
                k = '0;
            end
        end else begin
            k = (flags_reg[dfs_pkg::FLG_DROP_FULL] && (fill_reg == dfs_pkg::FULL_FILL)) ?
                PW'(1) : PW'(0);
        end
        ks = (k > {1'b0, fill_reg}) ? fill_reg : k[CW-1:0];
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        flags_next     = flags_reg;
        t_next         = t_reg;
        b_next         = b_reg;
        sp_next        = sp_reg;
        inside_next    = inside_reg;
        res_found_next = res_found_reg;
        res_start_next = res_start_reg;
        res_len_next   = res_len_reg;
        res_mem_next   = res_mem_reg;
        res_ovf_next   = res_ovf_reg;
        out_load       = 1'b0;
        unique case (state_reg)
            dfs_pkg::ST_IDLE: begin
                if (in_acc) begin
                    flags_next     = s_tdata[12:8];
                    res_found_next = 1'b0;
                    res_len_next   = '0;
                    res_mem_next   = '0;
                    if (s_tuser == dfs_pkg::CMD_PUSH) begin
                        res_start_next = '0;
                        res_ovf_next   = (fill_reg == dfs_pkg::FULL_FILL);
                        if (fill_reg != dfs_pkg::FULL_FILL)
                            fill_next = fill_reg + CW'(1);
                        state_next = dfs_pkg::ST_OUT;
                    end else begin
                        res_start_next = fill_reg;
                        res_ovf_next   = 1'b0;
                        state_next     = dfs_pkg::ST_CHECK;
                    end
                end
            end
            dfs_pkg::ST_CHECK: begin
                t_next = '0;
                priority if ((fill_reg == '0) || (hl == 4'd0)) begin
                    state_next = dfs_pkg::ST_OUT;
                end else if ({1'b0, fill_reg} < need) begin
                    state_next = dfs_pkg::ST_DROP;
                end else begin
                    state_next = dfs_pkg::ST_A_RD;
                end
            end
            dfs_pkg::ST_A_RD: begin
                state_next = dfs_pkg::ST_A_EV;
            end
            dfs_pkg::ST_A_EV: begin
                t_next = t_inc;
                if (t_reg == {1'b0, fill_reg} + PW'(6)) begin
                    b_next      = '0;
                    sp_next     = '0;
                    inside_next = 1'b0;
                    state_next  = dfs_pkg::ST_S_RD;
                end else begin
                    state_next = dfs_pkg::ST_A_RD;
                end
            end
            dfs_pkg::ST_S_RD: begin
                state_next = dfs_pkg::ST_SCAN;
            end
            dfs_pkg::ST_SCAN: begin
                state_next = dfs_pkg::ST_S_RD;
                priority if (b_reg >= b_lim) begin
                    state_next = dfs_pkg::ST_DROP;
                end else if (!inside_reg) begin
                    b_next = b_reg + CW'(1);
                    if (first) begin
                        inside_next = 1'b1;
                        sp_next     = bi;
                        if (last) begin
                            res_found_next = 1'b1;
                            res_start_next = b_reg + CW'(1) - CW'(hl);
                            res_len_next   = CW'(hl) + CW'(tl);
                            state_next     = dfs_pkg::ST_DROP;
                        end
                    end
                end else if (forb) begin
                    inside_next = 1'b0;
                    b_next      = {1'b0, sp_reg} + CW'(1);
                end else if (last) begin
                    res_found_next = 1'b1;
                    res_start_next = {1'b0, sp_reg} + CW'(1) - CW'(hl);
                    res_len_next   = cur + CW'(hl) + CW'(tl);
                    state_next     = dfs_pkg::ST_DROP;
                end else begin
                    b_next = b_reg + CW'(1);
                end
            end
            dfs_pkg::ST_DROP: begin
                if (res_found_reg)
                    res_mem_next = oldest_reg + res_start_reg[AW-1:0];
                oldest_next = oldest_reg + ks[AW-1:0];
                fill_next   = fill_reg - ks;
                state_next  = flags_reg[dfs_pkg::FLG_SKIP_HEAD] ? dfs_pkg::ST_H0_RD :
                                                                  dfs_pkg::ST_OUT;
            end
            dfs_pkg::ST_H0_RD: begin
                state_next = (fill_reg == '0) ? dfs_pkg::ST_OUT : dfs_pkg::ST_H0_EV;
            end
            dfs_pkg::ST_H0_EV: begin
                if (rdata_reg != dfs_pkg::pat_byte(cfg.head_pattern, 3'd0)) begin
                    oldest_next = oldest_reg + AW'(1);
                    fill_next   = fill_reg - CW'(1);
                    state_next  = dfs_pkg::ST_H0_RD;
                end else begin
                    state_next = dfs_pkg::ST_OUT;
                end
            end
            dfs_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = dfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dfs_pkg::ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        flags_reg     <= flags_next;
        t_reg         <= t_next;
        b_reg         <= b_next;
        sp_reg        <= sp_next;
        inside_reg    <= inside_next;
        res_found_reg <= res_found_next;
        res_start_reg <= res_start_next;
        res_len_reg   <= res_len_next;
        res_mem_reg   <= res_mem_next;
        res_ovf_reg   <= res_ovf_next;
        if (state_reg == dfs_pkg::ST_CHECK) begin
            hh_reg <= '0;
            th_reg <= '0;
        end else if (state_reg == dfs_pkg::ST_A_EV) begin
            hh_reg <= hh_next;
            th_reg <= th_next;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0000, res_ovf_reg, fill_reg, res_mem_reg, res_len_reg,
                            res_start_reg};
            m_tuser_reg <= res_found_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

/* rtl/core/dfs_checker.sv */
// ----------------------------------------------------------------------------
// dfs_checker
// Port-level checks on the result and input channels of the frame search block.
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dfs_pkg::OUT_DW-1:0]    m_tdata,
    input wire logic                          m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result transaction changed while stalled");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[17:9] == 9'd0) && (m_tdata[25:18] == 8'd0))
        else $error("result without frame carries length or address");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:26] <= dfs_pkg::FULL_FILL)
        else $error("fill beyond store depth");

    a_found_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> !m_tdata[35] && (m_tdata[17:9] != 9'd0))
        else $error("found frame with overflow or zero length");

    a_take_once: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready straight after a transaction");

endmodule

bind delimited_frame_search_top dfs_checker u_dfs_checker (.*);

`default_nettype wire

/* tb/tb_delimited_frame_search_top.sv */
// ----------------------------------------------------------------------------
// tb_delimited_frame_search_top
// Self-checking bench for the delimited frame search block: pushes and
// searches are streamed in with random gaps and back-pressure, every result is
// predicted by a behavioural copy of the byte store and frame finder, and the
// block is taken through a series of framing set-ups between quiet points.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_delimited_frame_search_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic       cmd;
        logic [7:0] data;
        logic [4:0] flags;
    } cmd_item_t;

    typedef struct {
        logic       found;
        logic [8:0] start;
        logic [8:0] len;
        logic [7:0] mem_idx;
        logic [8:0] fill;
        logic       ovf;
    } frame_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [dfs_pkg::IN_DW-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [dfs_pkg::OUT_DW-1:0] m_tdata;
    logic m_tuser;
    logic cfg_we = 1'b0;
    logic [dfs_pkg::CFG_AW-1:0] cfg_addr = '0;
    logic [dfs_pkg::PATW-1:0] cfg_wdata = '0;

    delimited_frame_search_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    cmd_item_t  pending[$];
    frame_res_t expected_res[$];
    int errors = 0;
    bit gaps_on = 1'b1;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int tx_gap = 0;
    int rx_stall = 0;

    // shadow of the block
    logic [7:0]  mem_img[dfs_pkg::DEPTH];
    int          oldest_q = 0;
    int          held = 0;
    logic [63:0] c_head = '0;
    int          c_hlen = 1;
    logic [63:0] c_tail = '0;
    int          c_tlen = 0;
    int          c_min = 0;
    int          c_max = 0;
    int          c_pol = 0;

    function automatic logic [7:0] held_byte(int v);
        return mem_img[(oldest_q + v) % dfs_pkg::DEPTH];
    endfunction

    function automatic void discard(int k);
        if (k > held) k = held;
        oldest_q = (oldest_q + k) % dfs_pkg::DEPTH;
        held -= k;
    endfunction

    // 0 unrelated, 1 equals a pattern byte, 2 inside a complete occurrence
    function automatic int pattern_hit(int pos, logic [63:0] patt, int len, bit hi_first,
                                       output int idx);
        int n, lo, hi, sh;
        bit ok;
        idx = 0;
        n = held;
        if (n == 0 || len == 0 || pos >= n) return 0;
        if (n >= len) begin
            lo = (pos > n - len) ? pos - (n - len) : 0;
            hi = (pos < len - 1) ? pos + 1 : len;
            for (int s = 0; s < hi - lo; s++) begin
                sh = hi_first ? hi - 1 - s : lo + s;
                ok = 1'b1;
                for (int p = 0; p < len; p++)
                    if (held_byte(pos - sh + p) != patt[8*p +: 8]) ok = 1'b0;
                if (ok) begin
                    idx = sh;
                    return 2;
                end
            end
        end
        for (int p = 0; p < len; p++) begin
            sh = hi_first ? len - 1 - p : p;
            if (held_byte(pos) == patt[8*sh +: 8]) begin
                idx = sh;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit locate_frame(output int start, output int flen);
        int n, hl, tl, pol, sp, b, hi, ti, li, hpart, tpart, cur;
        bit in_frame, forb, first, last;
        n = held;
        hl = (c_hlen > dfs_pkg::MAXP) ? dfs_pkg::MAXP : c_hlen;
        tl = (c_tlen > dfs_pkg::MAXP) ? dfs_pkg::MAXP : c_tlen;
        pol = (c_pol > 2) ? 0 : c_pol;
        in_frame = 1'b0;
        sp = 0;
        b = 0;
        start = 0;
        flen = 0;
        if (n == 0 || hl == 0) return 1'b0;
        if (n < hl + c_min + tl) return 1'b0;
        while (b < n - tl) begin
            hpart = pattern_hit(b, c_head, hl, 1'b1, hi);
            tpart = pattern_hit(b, c_tail, tl, 1'b0, ti);
            forb = pol != 0 && (hpart == 2 || tpart == 2 ||
                   (pol == 2 && (hpart == 1 || tpart == 1)));
            cur = in_frame ? b - sp : 0;
            first = (hpart == 2) && (hi == hl - 1);
            last = 1'b0;
            if (c_max != 0 && cur > c_max) forb = 1'b1;
            if (cur >= c_min) begin
                if (tl == 0) last = 1'b1;
                else last = pattern_hit(b + 1, c_tail, tl, 1'b0, li) == 2 && li == 0;
            end
            if (!in_frame) begin
                if (first) begin
                    in_frame = 1'b1;
                    sp = b;
                    if (last) begin
                        start = b + 1 - hl;
                        flen = hl + tl;
                        return 1'b1;
                    end
                end
            end else if (forb) begin
                in_frame = 1'b0;
                b = sp;
            end else if (last) begin
                start = sp + 1 - hl;
                flen = cur + hl + tl;
                return 1'b1;
            end
            b++;
        end
        return 1'b0;
    endfunction

    function automatic frame_res_t frame_store_step(cmd_item_t it);
        frame_res_t r;
        int st, ln;
        r = '{default: '0};
        if (it.cmd == dfs_pkg::CMD_PUSH) begin
            if (held >= dfs_pkg::DEPTH) begin
                r.ovf = 1'b1;
            end else begin
                mem_img[(oldest_q + held) % dfs_pkg::DEPTH] = it.data;
                held++;
            end
        end else begin
            r.start = 9'(held);
            if (held != 0 && c_hlen != 0) begin
                if (locate_frame(st, ln)) begin
                    r.found = 1'b1;
                    r.start = 9'(st);
                    r.len = 9'(ln);
                    r.mem_idx = 8'((oldest_q + st) % dfs_pkg::DEPTH);
                    if (it.flags[dfs_pkg::FLG_DROP_FRAME] || it.flags[dfs_pkg::FLG_DROP_ONE] ||
                        it.flags[dfs_pkg::FLG_DROP_BEFORE]) begin
                        discard(st);
                        if (it.flags[dfs_pkg::FLG_DROP_FRAME]) discard(ln);
                        else if (it.flags[dfs_pkg::FLG_DROP_ONE]) discard(1);
                    end
                end else if (it.flags[dfs_pkg::FLG_DROP_FULL] && held == dfs_pkg::DEPTH) begin
                    discard(1);
                end
                if (it.flags[dfs_pkg::FLG_SKIP_HEAD])
                    while (held > 0 && held_byte(0) != c_head[7:0]) discard(1);
            end
        end
        r.fill = 9'(held);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic void queue_cmd(logic cmd, logic [7:0] data, logic [4:0] flags);
        cmd_item_t it;
        it.cmd = cmd;
        it.data = data;
        it.flags = flags;
        pending.push_back(it);
    endfunction

    // sender: hold a transaction until taken, predict on acceptance
    always @(posedge aclk) begin
        cmd_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                it.cmd = s_tuser;
                it.data = s_tdata[7:0];
                it.flags = s_tdata[12:8];
                expected_res.push_back(frame_store_step(it));
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                it = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.cmd;
                s_tdata <= {3'b000, it.flags, it.data};
                if (gaps_on && $urandom_range(0, 5) == 0) tx_gap <= $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (gaps_on && $urandom_range(0, 5) == 0) rx_stall <= $urandom_range(1, 15);
        end
    end

    always @(posedge aclk) begin
        frame_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_res.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                w = expected_res.pop_front();
                if (m_tuser !== w.found) report("found", m_tuser, w.found);
                if (m_tdata[8:0] !== w.start) report("frame_start", m_tdata[8:0], w.start);
                if (m_tdata[17:9] !== w.len) report("frame_len", m_tdata[17:9], w.len);
                if (m_tdata[25:18] !== w.mem_idx)
                    report("frame_mem_index", m_tdata[25:18], w.mem_idx);
                if (m_tdata[34:26] !== w.fill) report("fill_after", m_tdata[34:26], w.fill);
                if (m_tdata[35] !== w.ovf) report("overflow", m_tdata[35], w.ovf);
            end
        end
    end

    task automatic set_reg(dfs_pkg::reg_idx_t idx, logic [63:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        case (idx)
            dfs_pkg::REG_HEAD_PATTERN: c_head = v;
            dfs_pkg::REG_HEAD_LEN:     c_hlen = int'(v[3:0]);
            dfs_pkg::REG_TAIL_PATTERN: c_tail = v;
            dfs_pkg::REG_TAIL_LEN:     c_tlen = int'(v[3:0]);
            dfs_pkg::REG_MIN_LEN:      c_min = int'(v[8:0]);
            dfs_pkg::REG_MAX_LEN:      c_max = int'(v[8:0]);
            dfs_pkg::REG_FRAME_POLICY: c_pol = int'(v[1:0]);
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0 || s_tvalid || expected_res.size() > 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    initial begin
        int hl, tl, mn, mx, plen, added;
        logic [63:0] hp, tp;
        bit broken;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset framing: one-byte head of zero, no tail
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h1F);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'hFF, 5'h00);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h00, 5'h1F);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h5A, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'hFF, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h01);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'hA5, 5'h00);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h00, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h02);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h00, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h04);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h33, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h08);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h00, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h10);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h14);
        drain();
        set_reg(dfs_pkg::REG_HEAD_LEN, 64'd0);
        queue_cmd(dfs_pkg::CMD_PUSH, 8'h00, 5'h00);
        queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h1F);
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            hl = (ph == 1) ? 0 : (ph == 2 || ph == 9) ? 8 : $urandom_range(1, 8);
            tl = (ph == 3 || ph == 10) ? 8 : (ph % 3 == 0) ? 0 : $urandom_range(0, 8);
            mn = (ph == 4) ? 256 : $urandom_range(0, 3);
            mx = (ph == 4 || ph == 5) ? 256 : ($urandom_range(0, 2) == 0) ? 0 :
                 mn + $urandom_range(0, 8);
            hp = (ph == 6) ? '1 : (ph == 7) ? '0 : {$urandom, $urandom};
            tp = (ph == 6) ? '0 : (ph == 7) ? '1 : {$urandom, $urandom};
            set_reg(dfs_pkg::REG_HEAD_PATTERN, hp);
            set_reg(dfs_pkg::REG_HEAD_LEN, 64'(hl));
            set_reg(dfs_pkg::REG_TAIL_PATTERN, tp);
            set_reg(dfs_pkg::REG_TAIL_LEN, 64'(tl));
            set_reg(dfs_pkg::REG_MIN_LEN, 64'(mn));
            set_reg(dfs_pkg::REG_MAX_LEN, 64'(mx));
            set_reg(dfs_pkg::REG_FRAME_POLICY, 64'(ph % 3));
            if (ph == 8) hold_go = 1'b1;
            if (ph == 13) gaps_on = 1'b0;
            added = 0;
            while (added < 52) begin
                broken = $urandom_range(0, 4) == 0;
                repeat ($urandom_range(0, 2)) begin
                    queue_cmd(dfs_pkg::CMD_PUSH, 8'($urandom), 5'($urandom));
                    added++;
                end
                for (int i = 0; i < hl; i++) begin
                    if (!(broken && i == hl - 1)) begin
                        queue_cmd(dfs_pkg::CMD_PUSH, hp[8*i +: 8], 5'($urandom));
                        added++;
                    end
                end
                plen = mn + $urandom_range(0, (mx == 0 || mx < mn) ? 6 :
                                              ((mx - mn > 6) ? 6 : mx - mn));
                if (plen > 20) plen = 20;
                repeat (plen) begin
                    queue_cmd(dfs_pkg::CMD_PUSH, 8'($urandom), 5'($urandom));
                    added++;
                end
                for (int i = 0; i < tl; i++) begin
                    queue_cmd(dfs_pkg::CMD_PUSH, tp[8*i +: 8], 5'($urandom));
                    added++;
                end
                queue_cmd(dfs_pkg::CMD_SEARCH, 8'($urandom), 5'($urandom));
                added++;
            end
            // fill the store to overflow once
            if (ph == 11) begin
                repeat (270) queue_cmd(dfs_pkg::CMD_PUSH, 8'($urandom), 5'h00);
                queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h08);
                queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h1C);
                queue_cmd(dfs_pkg::CMD_SEARCH, 8'h00, 5'h10);
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_delimited_frame_search_top passed");
        end else begin
            $display("tb_delimited_frame_search_top failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb_delimited_frame_search_top failed");
        $finish;
    end

endmodule

`default_nettype wire

/* delimited_frame_search_top.f */
rtl/core/dfs_pkg.sv
rtl/core/dfs_cfg_regs.sv
rtl/core/delimited_frame_search_top.sv
rtl/core/dfs_checker.sv
tb/tb_delimited_frame_search_top.sv
